[rtl/core/rpfs_pkg.sv]
`default_nettype none

package rpfs_pkg;

	// number of cells in the chain (1 .. 64)
	localparam int CELLS = 64;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam int BYTE_W = 8;
	localparam int COLOR_W = 3 * BYTE_W;
	localparam int CELL_NUM_W = 6;
	localparam int HELD_BYTES = 3;

	// index byte that blackens the whole store
	localparam logic [BYTE_W-1:0] CLEAR_CODE = 8'd64;
	// byte_count value of the index byte (fourth of a packet)
	localparam logic [1:0] INDEX_SLOT = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} rpfs_state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic              hold;     // store rx_byte as a colour byte
		logic [1:0]        hold_sel; // which colour byte
		logic              commit;   // index byte: write or clear the store
		logic              rd_en;    // read one cell for scan-out
		logic [CELL_W-1:0] rd_addr;
		logic              rd_last;
	} rpfs_cmd_t;

endpackage

`default_nettype wire

[rtl/core/rpfs_ram.sv]
`default_nettype none

module rpfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                        wdata,
	input  wire                                     re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/rpfs_ctrl.sv]
`default_nettype none

module rpfs_ctrl import rpfs_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	output rpfs_cmd_t  cmd
);

	rpfs_state_t       state_q;
	logic [1:0]        byte_count_q;
	logic [CELL_W-1:0] scan_cnt_q;
	logic              accept;
	logic              scan_last;

	assign busy      = (state_q == ST_SCAN);
	assign accept    = start && !busy;
	assign scan_last = (scan_cnt_q == CELL_W'(CELLS - 1));

	always_comb begin
		cmd          = '0;
		cmd.hold     = accept && (byte_count_q != INDEX_SLOT);
		cmd.hold_sel = byte_count_q;
		cmd.commit   = accept && (byte_count_q == INDEX_SLOT);
		cmd.rd_en    = (state_q == ST_SCAN);
		cmd.rd_addr  = scan_cnt_q;
		cmd.rd_last  = scan_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byte_count_q <= '0;
			scan_cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						byte_count_q <= byte_count_q + 2'd1;
						if (byte_count_q == INDEX_SLOT) begin
							state_q    <= ST_SCAN;
							scan_cnt_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_IDLE;
					end else begin
						scan_cnt_q <= scan_cnt_q + CELL_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_last) |=> (state_q == ST_IDLE))
		else $error("scan did not end after last cell");

	a_commit_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == ST_SCAN && scan_cnt_q == '0))
		else $error("index byte did not start a scan at cell 0");

	a_no_store_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (!cmd.hold && !cmd.commit))
		else $error("byte taken during scan-out");

endmodule

`default_nettype wire

[rtl/core/rpfs_dp.sv]
`default_nettype none

module rpfs_dp import rpfs_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [BYTE_W-1:0]     rx_byte,
	input  rpfs_cmd_t             cmd,
	output logic                  strobe,
	output logic [BYTE_W-1:0]     green,
	output logic [BYTE_W-1:0]     red,
	output logic [BYTE_W-1:0]     blue,
	output logic [CELL_NUM_W-1:0] cell_number,
	output logic                  last_cell
);

	logic [BYTE_W-1:0]     held_q [HELD_BYTES];
	logic [CELLS-1:0]      valid_q;
	logic                  idx_clear;
	logic                  idx_write;
	logic [COLOR_W-1:0]    wdata;
	logic [COLOR_W-1:0]    rdata;
	logic                  valid_s1;
	logic                  strobe_s1;
	logic                  last_s1;
	logic [CELL_W-1:0]     addr_s1;

	assign idx_clear = cmd.commit && (rx_byte == CLEAR_CODE);
	// any other index below the cell count writes; all others are dropped
	assign idx_write = cmd.commit && !idx_clear && (rx_byte < BYTE_W'(CELLS));
	assign wdata     = {held_q[0], held_q[1], held_q[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HELD_BYTES; i++) begin
				held_q[i] <= '0;
			end
		end else if (cmd.hold) begin
			held_q[cmd.hold_sel] <= rx_byte;
		end
	end

	// per-cell valid: an unwritten or cleared cell reads black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (idx_clear) begin
			valid_q <= '0;
		end else if (idx_write) begin
			valid_q[rx_byte[CELL_W-1:0]] <= 1'b1;
		end
	end

	rpfs_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (idx_write),
		.waddr (rx_byte[CELL_W-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			valid_s1  <= 1'b0;
			addr_s1   <= '0;
		end else begin
			strobe_s1 <= cmd.rd_en;
			if (cmd.rd_en) begin
				last_s1  <= cmd.rd_last;
				valid_s1 <= valid_q[cmd.rd_addr];
				addr_s1  <= cmd.rd_addr;
			end
		end
	end

	assign strobe      = strobe_s1;
	assign red         = valid_s1 ? rdata[23:16] : '0;
	assign green       = valid_s1 ? rdata[15:8]  : '0;
	assign blue        = valid_s1 ? rdata[7:0]   : '0;
	assign cell_number = CELL_NUM_W'(addr_s1);
	assign last_cell   = strobe_s1 && last_s1;

	a_last_is_top_cell: assert property (@(posedge clk) disable iff (!arst_n)
		last_cell |-> (cell_number == CELL_NUM_W'(CELLS - 1)))
		else $error("last cell flag on wrong cell");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_cell |=> !strobe)
		else $error("result right after last cell");

endmodule

`default_nettype wire

[rtl/core/rgb_packet_frame_store_scanout.sv]
`default_nettype none

// RGB packet frame store with scan-out.
//
// Input: one received byte per item on rx_byte, taken at a rising edge with
// start high and busy low. Bytes form packets of four: red, green, blue, then
// the cell index. The first three bytes are only held (no result, busy stays
// low). The index byte writes that cell's colour, or with
// code 64 blackens every cell; other indices of CELLS and above are dropped.
// After each index byte the whole store is scanned out: CELLS results on
// consecutive cycles, each valid for exactly one cycle while strobe is high,
// in cell order, colour given as green/red/blue, last_cell on the final cell.
// The index byte starts the scan sequencer; each cell is read from the store
// and registered with its valid flag before it shows as a result. busy is
// high while the cells are read from the store, and no byte is taken then.
// The receiver cannot stall; results simply go by.
// Reset: the partial packet is dropped and all cells read black (per-cell
// valid flags cleared at once; no clearing pass needed).

module rgb_packet_frame_store_scanout import rpfs_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire  [BYTE_W-1:0]     rx_byte,
	output logic                  strobe,
	output logic [BYTE_W-1:0]     green,
	output logic [BYTE_W-1:0]     red,
	output logic [BYTE_W-1:0]     blue,
	output logic [CELL_NUM_W-1:0] cell_number,
	output logic                  last_cell
);

	// commands from the sequencer to the store datapath
	rpfs_cmd_t cmd;

	// packet byte counter and scan sequencer
	rpfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// held colour bytes, frame store RAM, valid flags and result register
	rpfs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.strobe      (strobe),
		.green       (green),
		.red         (red),
		.blue        (blue),
		.cell_number (cell_number),
		.last_cell   (last_cell)
	);

endmodule

`default_nettype wire
